// ===== rtl/vwr_pkg.sv =====
// Shared types and constants for the vertex weld and remap core.
package vwr_pkg;

   localparam int DEFAULT_MAX_VERTS = 1024;
   localparam int COORD_W           = 24;
   localparam int CORNER_W          = 10;
   localparam int THR_W             = 16;
   localparam int STATUS_W          = 2;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd41;

   localparam logic [1:0] REQ_VERTEX   = 2'd0;
   localparam logic [1:0] REQ_TRIANGLE = 2'd1;
   localparam logic [1:0] REQ_CLEAR    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [CORNER_W-1:0]       corner_a;
      logic [CORNER_W-1:0]       corner_b;
      logic [CORNER_W-1:0]       corner_c;
   } vwr_req_type;

   typedef struct packed {
      logic [CORNER_W-1:0] unique_index;
      logic                is_new;
      logic [CORNER_W-1:0] out_a;
      logic [CORNER_W-1:0] out_b;
      logic [CORNER_W-1:0] out_c;
      logic [STATUS_W-1:0] status;
   } vwr_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vwr_point_type;

endpackage

// ===== rtl/vertex_weld_remap_core.sv =====
// Vertex weld and remap core: one item at a time, unique store and remap table in RAM.
// Takes one word at a time. A vertex scans the unique store one entry per cycle through
// a read, square and compare pipeline, stopping at the first match. A triangle reads its
// three corners in turn from the single remap read port.
// A finished result waits in the output register while the next word is accepted.
module vertex_weld_remap_core
   import vwr_pkg::*;
#(
   parameter int MAX_VERTS = DEFAULT_MAX_VERTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  vwr_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vwr_rsp_type        rsp_data,
   input  logic               csr_wr_en,
   input  logic [THR_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int SQ_W  = 2 * (COORD_W + 1);
   localparam int SUM_W = SQ_W + 2;

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_SCAN       = 5'b00010,
      ST_REMAP      = 5'b00100,
      ST_REMAP_WAIT = 5'b01000,
      ST_RESP       = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   vwr_req_type        cur_ff, cur_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [31:0]        thr2_ff;
   logic [CNT_W-1:0]   unique_cnt_ff, unique_cnt_in;
   logic [CNT_W-1:0]   orig_cnt_ff, orig_cnt_in;
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               p1_v_ff, p1_v_in;
   logic [CNT_W-1:0]   p1_idx_ff;
   logic               p2_v_ff, p2_v_in;
   logic [CNT_W-1:0]   p2_idx_ff;
   logic [SQ_W-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic [1:0]         rd_cnt_ff, rd_cnt_in;
   logic               rd_v_ff, rd_v_in;
   logic [1:0]         rd_slot_ff;
   vwr_rsp_type        res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vwr_rsp_type        rsp_data_ff;
   logic               rsp_load;

   vwr_point_type      store_mem [MAX_VERTS];
   vwr_point_type      store_rd_ff;
   logic [IDX_W-1:0]   remap_mem [MAX_VERTS];
   logic [IDX_W-1:0]   remap_rd_ff;

   logic               store_we, remap_we;
   logic [IDX_W-1:0]   remap_raddr;
   logic [IDX_W-1:0]   found;

   logic               issue, hit, miss_done;
   logic [SUM_W-1:0]   dist_sum;
   logic [COORD_W:0]   dx, dy, dz;
   logic [COORD_W:0]   mx, my, mz;
   logic [2:0]         corner_ok;
   logic [31:0]        ca32, cb32, cc32, csel32, found32, rr32;
   logic [CORNER_W-1:0] rd_val;

   // Corner range checks against the number of vertices seen since the last clear.
   always_comb begin
      ca32 = 32'(cur_ff.corner_a);
      cb32 = 32'(cur_ff.corner_b);
      cc32 = 32'(cur_ff.corner_c);
      corner_ok[0] = ca32 < 32'(orig_cnt_ff);
      corner_ok[1] = cb32 < 32'(orig_cnt_ff);
      corner_ok[2] = cc32 < 32'(orig_cnt_ff);
      case (rd_cnt_ff)
         2'd0:    csel32 = ca32;
         2'd1:    csel32 = cb32;
         default: csel32 = cc32;
      endcase
      remap_raddr = csel32[IDX_W-1:0];
      rr32   = 32'(remap_rd_ff);
      rd_val = corner_ok[rd_slot_ff] ? rr32[CORNER_W-1:0] : '0;
   end

   // Squared distance of the entry in the second stage.
   always_comb begin
      dx = {cur_ff.coord_x[COORD_W-1], cur_ff.coord_x} - {store_rd_ff.x[COORD_W-1], store_rd_ff.x};
      dy = {cur_ff.coord_y[COORD_W-1], cur_ff.coord_y} - {store_rd_ff.y[COORD_W-1], store_rd_ff.y};
      dz = {cur_ff.coord_z[COORD_W-1], cur_ff.coord_z} - {store_rd_ff.z[COORD_W-1], store_rd_ff.z};
      mx = dx[COORD_W] ? -dx : dx;
      my = dy[COORD_W] ? -dy : dy;
      mz = dz[COORD_W] ? -dz : dz;
      dist_sum = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
   end

   assign issue     = scan_idx_ff < unique_cnt_ff;
   assign hit       = p2_v_ff && (dist_sum <= SUM_W'(thr2_ff));
   assign miss_done = !issue && !p1_v_ff && !p2_v_ff;
   assign found     = hit ? p2_idx_ff[IDX_W-1:0] : unique_cnt_ff[IDX_W-1:0];
   assign found32   = 32'(found);
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      thr_in        = csr_wr_en ? csr_wr_data : thr_ff;
      unique_cnt_in = unique_cnt_ff;
      orig_cnt_in   = orig_cnt_ff;
      scan_idx_in   = scan_idx_ff;
      p1_v_in       = 1'b0;
      p2_v_in       = 1'b0;
      rd_cnt_in     = rd_cnt_ff;
      rd_v_in       = 1'b0;
      res_in        = res_ff;
      store_we      = 1'b0;
      remap_we      = 1'b0;

      // Drop each remap read into its corner slot.
      if (rd_v_ff) begin
         case (rd_slot_ff)
            2'd0:    res_in.out_a = rd_val;
            2'd1:    res_in.out_b = rd_val;
            default: res_in.out_c = rd_val;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_data;
               res_in = '0;
               state_in = ST_RESP;
               case (req_data.req_type)
                  REQ_VERTEX: begin
                     if (orig_cnt_ff >= CNT_W'(MAX_VERTS)) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        scan_idx_in = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_TRIANGLE: begin
                     rd_cnt_in = '0;
                     state_in = ST_REMAP;
                  end
                  REQ_CLEAR: begin
                     unique_cnt_in = '0;
                     orig_cnt_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            p1_v_in = issue;
            p2_v_in = p1_v_ff;
            scan_idx_in = scan_idx_ff + CNT_W'(issue);
            if (hit || miss_done) begin
               // First hit in store order wins; flush what is still in flight.
               p1_v_in = 1'b0;
               p2_v_in = 1'b0;
               remap_we = 1'b1;
               store_we = !hit;
               if (!hit) unique_cnt_in = unique_cnt_ff + 1'b1;
               orig_cnt_in = orig_cnt_ff + 1'b1;
               res_in.unique_index = found32[CORNER_W-1:0];
               res_in.is_new = !hit;
               state_in = ST_RESP;
            end
         end
         ST_REMAP: begin
            rd_v_in = 1'b1;
            rd_cnt_in = rd_cnt_ff + 2'd1;
            if (rd_cnt_ff == 2'd2) state_in = ST_REMAP_WAIT;
         end
         ST_REMAP_WAIT: begin
            if (corner_ok != 3'b111) res_in.status = STATUS_BAD_INDEX;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= THRESHOLD_RESET;
         unique_cnt_ff <= '0;
         orig_cnt_ff   <= '0;
         p1_v_ff       <= 1'b0;
         p2_v_ff       <= 1'b0;
         rd_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         unique_cnt_ff <= unique_cnt_in;
         orig_cnt_ff   <= orig_cnt_in;
         p1_v_ff       <= p1_v_in;
         p2_v_ff       <= p2_v_in;
         rd_v_ff       <= rd_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      thr2_ff     <= 32'(thr_ff) * 32'(thr_ff);
      scan_idx_ff <= scan_idx_in;
      p1_idx_ff   <= scan_idx_ff;
      p2_idx_ff   <= p1_idx_ff;
      sq_x_ff     <= SQ_W'(mx) * SQ_W'(mx);
      sq_y_ff     <= SQ_W'(my) * SQ_W'(my);
      sq_z_ff     <= SQ_W'(mz) * SQ_W'(mz);
      rd_cnt_ff   <= rd_cnt_in;
      rd_slot_ff  <= rd_cnt_ff;
      res_ff      <= res_in;
      if (rsp_load) rsp_data_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[unique_cnt_ff[IDX_W-1:0]] <= '{x: cur_ff.coord_x, y: cur_ff.coord_y,
                                                  z: cur_ff.coord_z};
      end
      store_rd_ff <= store_mem[scan_idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (remap_we) remap_mem[orig_cnt_ff[IDX_W-1:0]] <= found;
      remap_rd_ff <= remap_mem[remap_raddr];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== bench/tb_vertex_weld_remap_core.sv =====
// Self-checking testbench for the vertex weld and remap core.
module tb_vertex_weld_remap_core;
   timeunit 1ns;
   timeprecision 1ps;
   import vwr_pkg::*;

   localparam int MAX_V     = DEFAULT_MAX_VERTS;
   localparam int CYC_LIMIT = 8000000;
   localparam int REQ_BITS  = $bits(vwr_req_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   vwr_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   vwr_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;

   vertex_weld_remap_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   vwr_point_type    weld_pts[MAX_V];
   logic [9:0]       orig_to_unique[MAX_V];
   int               n_unique;
   int               n_orig;
   logic [THR_W-1:0] weld_thr;

   vwr_rsp_type expected_rsps[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   function automatic longint unsigned sq_delta(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return longint'(d) * longint'(d);
   endfunction

   function automatic logic [9:0] remap_lookup(logic [9:0] c, ref logic bad);
      if (int'(c) >= n_orig) begin
         bad = 1'b1;
         return '0;
      end
      return orig_to_unique[c];
   endfunction

   function automatic vwr_rsp_type weld_predict(vwr_req_type r);
      vwr_rsp_type      o;
      longint unsigned  thr2, sq_sum;
      int               found;
      logic             bad;
      o = '0;
      bad = 1'b0;
      found = -1;
      case (r.req_type)
         REQ_VERTEX: begin
            if (n_orig >= MAX_V) begin
               o.status = STATUS_FULL;
            end else begin
               thr2 = longint'(weld_thr) * longint'(weld_thr);
               for (int j = 0; j < n_unique; j++) begin
                  sq_sum = sq_delta(weld_pts[j].x, r.coord_x) + sq_delta(weld_pts[j].y, r.coord_y)
                         + sq_delta(weld_pts[j].z, r.coord_z);
                  if (sq_sum <= thr2) begin
                     found = j;
                     break;
                  end
               end
               if (found < 0) begin
                  found = n_unique;
                  weld_pts[found] = '{r.coord_x, r.coord_y, r.coord_z};
                  n_unique++;
                  o.is_new = 1'b1;
               end
               orig_to_unique[n_orig] = found[9:0];
               n_orig++;
               o.unique_index = found[9:0];
            end
         end
         REQ_TRIANGLE: begin
            o.out_a = remap_lookup(r.corner_a, bad);
            o.out_b = remap_lookup(r.corner_b, bad);
            o.out_c = remap_lookup(r.corner_c, bad);
            o.status = bad ? STATUS_BAD_INDEX : STATUS_OK;
         end
         REQ_CLEAR: begin
            n_unique = 0;
            n_orig = 0;
         end
         default: ;
      endcase
      return o;
   endfunction

   // receive side: compare each result word against the oldest expectation
   always @(posedge clock) begin
      vwr_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (cycle_count >= CYC_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // send one word; without a fixed expectation the predictor supplies it
   task automatic send_word(vwr_req_type r, logic has_fixed, vwr_rsp_type fixed);
      vwr_rsp_type p;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      p = weld_predict(r);
      if (has_fixed && p !== fixed) begin
         $display("%0t: table row disagrees: expected %p predicted %p", $time, fixed, p);
         fail_count++;
      end
      expected_rsps.push_back(has_fixed ? fixed : p);
      @(negedge clock);
   endtask

   task automatic drain_and_write(logic [THR_W-1:0] thr);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (MAX_V + 20) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= thr;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      weld_thr = thr;
   endtask

   function automatic vwr_req_type mk_vertex(int x, int y, int z);
      vwr_req_type r;
      r = '0;
      r.req_type = REQ_VERTEX;
      r.coord_x = x[23:0];
      r.coord_y = y[23:0];
      r.coord_z = z[23:0];
      return r;
   endfunction

   function automatic vwr_req_type mk_tri(int a, int b, int c);
      vwr_req_type r;
      r = '0;
      r.req_type = REQ_TRIANGLE;
      r.corner_a = a[9:0];
      r.corner_b = b[9:0];
      r.corner_c = c[9:0];
      return r;
   endfunction

   function automatic vwr_req_type mk_other(logic [1:0] t);
      vwr_req_type r;
      r = REQ_BITS'({$urandom, $urandom});
      r.req_type = t;
      return r;
   endfunction

   function automatic vwr_rsp_type mk_rsp(int ui, bit nw, int st);
      vwr_rsp_type o;
      o = '0;
      o.unique_index = ui[9:0];
      o.is_new = nw;
      o.status = st[1:0];
      return o;
   endfunction

   typedef struct {
      vwr_req_type req;
      logic        fixed;
      vwr_rsp_type rsp;
   } stim_row_type;

   // random vertex near an earlier point, or anywhere
   function automatic vwr_req_type rand_vertex();
      vwr_req_type r;
      int j;
      int spread;
      r = mk_other(REQ_VERTEX);
      if (n_unique > 0 && $urandom_range(99) < 55) begin
         j = $urandom_range(n_unique - 1);
         spread = int'(weld_thr) + 2;
         r.coord_x = weld_pts[j].x + 24'($urandom_range(2 * spread) - spread);
         r.coord_y = weld_pts[j].y + 24'($urandom_range(2 * spread) - spread);
         r.coord_z = weld_pts[j].z + 24'($urandom_range(2 * spread) - spread);
      end else if ($urandom_range(3) == 0) begin
         r.coord_x = 24'($urandom_range(400)) - 24'd200;
         r.coord_y = 24'($urandom_range(400)) - 24'd200;
         r.coord_z = 24'($urandom_range(400)) - 24'd200;
      end
      return r;
   endfunction

   function automatic vwr_req_type rand_tri();
      int lim;
      lim = (n_orig > 0) ? n_orig - 1 : 0;
      if ($urandom_range(9) == 0)
         return mk_other(REQ_TRIANGLE);
      return mk_tri($urandom_range(lim), $urandom_range(lim),
                    ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(lim));
   endfunction

   task automatic random_phase(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 58) send_word(rand_vertex(), 1'b0, '0);
         else if (pick < 92) send_word(rand_tri(), 1'b0, '0);
         else if (pick < 96) send_word(mk_other(REQ_CLEAR), 1'b0, '0);
         else send_word(mk_other(2'd3), 1'b0, '0);
      end
   endtask

   initial begin
      stim_row_type dir_rows[$];
      n_unique = 0;
      n_orig = 0;
      weld_thr = THRESHOLD_RESET;

      // after reset: empty store, extremes, welds, bad corners, unknown and clear
      dir_rows.push_back('{mk_tri(0, 0, 0), 1'b1, mk_rsp(0, 1'b0, int'(STATUS_BAD_INDEX))});
      dir_rows.push_back('{mk_vertex(-8388608, -8388608, -8388608), 1'b1, mk_rsp(0, 1'b1, 0)});
      dir_rows.push_back('{mk_vertex(8388607, 8388607, 8388607), 1'b1, mk_rsp(1, 1'b1, 0)});
      dir_rows.push_back('{mk_vertex(8388607, 8388607, 8388607 - 41), 1'b1, mk_rsp(1, 1'b0, 0)});
      dir_rows.push_back('{mk_vertex(8388607, 8388607, 8388607 - 42), 1'b1, mk_rsp(2, 1'b1, 0)});
      dir_rows.push_back('{mk_vertex(0, 0, 0), 1'b1, mk_rsp(3, 1'b1, 0)});
      dir_rows.push_back('{mk_vertex(24, 24, 24), 1'b0, '0});
      dir_rows.push_back('{mk_vertex(-20, 20, -29), 1'b0, '0});
      dir_rows.push_back('{mk_tri(0, 3, 5), 1'b0, '0});
      dir_rows.push_back('{mk_tri(1023, 512, 7), 1'b0, '0});
      dir_rows.push_back('{mk_other(2'd3), 1'b1, '0});
      dir_rows.push_back('{mk_other(REQ_CLEAR), 1'b1, '0});
      dir_rows.push_back('{mk_tri(0, 1, 2), 1'b1, mk_rsp(0, 1'b0, int'(STATUS_BAD_INDEX))});
      dir_rows.push_back('{mk_vertex(-1, -1, -1), 1'b1, mk_rsp(0, 1'b1, 0)});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 18;
      recv_idle_pct = 66;
      foreach (dir_rows[i]) send_word(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

      // threshold zero: only exact copies weld
      drain_and_write('0);
      send_word(mk_vertex(-1, -1, -1), 1'b1, mk_rsp(0, 1'b0, 0));
      send_word(mk_vertex(-1, -1, 0), 1'b1, mk_rsp(1, 1'b1, 0));

      // fill the remap table to its limit, then overflow it
      drain_and_write(16'd200);
      send_word(mk_other(REQ_CLEAR), 1'b1, '0);
      for (int i = 0; i < MAX_V; i++)
         send_word(($urandom_range(3) == 0) ? rand_vertex() : mk_vertex(0, 0, i * 7), 1'b0, '0);
      send_word(mk_vertex(5, 5, 5), 1'b1, mk_rsp(0, 1'b0, int'(STATUS_FULL)));
      send_word(mk_tri(1023, 0, 511), 1'b0, '0);
      send_word(mk_other(REQ_CLEAR), 1'b1, '0);

      drain_and_write(16'd41);
      random_phase(150);

      send_idle_pct = 66;
      recv_idle_pct = 18;
      drain_and_write(16'hFFFF);
      random_phase(80);
      drain_and_write(16'd3000);
      random_phase(70);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain_and_write(16'd9);
      random_phase(150);

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (MAX_V + 20) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
